@@ rtl/ahb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the adaptive hedging budget block.
// Used by ahb_ctrl, ahb_dp and adaptive_hedging_budget_core; depends on nothing.
package ahb_pkg;

  // Parameter defaults
  localparam int COUNTER_BITS_DEF = 32;
  localparam int TIME_BITS_DEF    = 48;

  // Fixed field and register widths
  localparam int COUNT_W    = 16;
  localparam int DELAY_W    = 32;
  localparam int TICK_W     = 32;
  localparam int TUNE_W     = 16;
  localparam int TUNE_FRAC  = 8;
  localparam int RATIO_W    = 20;
  localparam int RATIO_FRAC = 16;
  localparam int TQ_W       = DELAY_W + TUNE_FRAC;
  localparam int OUT_DATA_W = ((DELAY_W + 1 + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TUNE_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_RATIO = 3'd4;

  // Register reset values
  localparam logic [TICK_W-1:0]  TICK_PERIOD_RST  = 32'd1000000;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST    = 32'd0;
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST    = 32'd100000;
  localparam logic [TUNE_W-1:0]  TUNE_FACTOR_RST  = 16'd512;
  localparam logic [RATIO_W-1:0] BACKUP_RATIO_RST = 20'd6554;

  // Item kinds
  localparam logic FUNC_PRIMARY = 1'b0;
  localparam logic FUNC_BACKUP  = 1'b1;

  // Operand selects of the serial units
  localparam logic LIM_SWITCH   = 1'b0;
  localparam logic LIM_APPROVE  = 1'b1;
  localparam logic WGT_BACKUP   = 1'b0;
  localparam logic WGT_PRIMARY  = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_period;
    logic [DELAY_W-1:0] min_delay;
    logic [DELAY_W-1:0] max_delay;
    logic [TUNE_W-1:0]  tune_factor;
    logic [RATIO_W-1:0] backup_ratio;
  } ahb_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LIM_SW,
    S_TUNE,
    S_SWITCH,
    S_ROUTE,
    S_WGT_B,
    S_WGT_P,
    S_LIM_AP,
    S_UPDATE,
    S_OUT
  } ahb_state_t;

  typedef struct packed {
    logic cap;
    logic lim_go;
    logic lim_sel;
    logic tune_go;
    logic sw_commit;
    logic wgt_go;
    logic wgt_sel;
    logic upd;
    logic out_load;
  } ahb_cmd_t;

  typedef struct packed {
    logic switch_due;
    logic func;
    logic prev_valid;
    logic lim_busy;
    logic tune_busy;
    logic wgt_busy;
    logic out_free;
  } ahb_sts_t;

endpackage

@@ rtl/ahb_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the adaptive hedging budget: walks one item through window
// switch, weighting, limit check and result. Depends on ahb_pkg.
module ahb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ahb_pkg::ahb_sts_t sts,
  output ahb_pkg::ahb_cmd_t cmd
);
  import ahb_pkg::*;

  ahb_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.switch_due ? S_LIM_SW : S_ROUTE;
      end
      S_LIM_SW: begin
        if (!sts.lim_busy) state_nxt = S_TUNE;
      end
      S_TUNE: begin
        if (!sts.tune_busy) state_nxt = S_SWITCH;
      end
      S_SWITCH: begin
        state_nxt = S_ROUTE;
      end
      S_ROUTE: begin
        if (sts.func == FUNC_PRIMARY) begin
          state_nxt = S_UPDATE;
        end else if (sts.prev_valid) begin
          state_nxt = S_WGT_B;
        end else begin
          state_nxt = S_LIM_AP;
        end
      end
      S_WGT_B: begin
        if (!sts.wgt_busy) state_nxt = S_WGT_P;
      end
      S_WGT_P: begin
        if (!sts.wgt_busy) state_nxt = S_LIM_AP;
      end
      S_LIM_AP: begin
        if (!sts.lim_busy) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      S_CHECK: begin
        cmd.lim_go  = sts.switch_due;
        cmd.lim_sel = LIM_SWITCH;
      end
      S_LIM_SW: begin
        cmd.tune_go = !sts.lim_busy;
      end
      S_TUNE: begin
      end
      S_SWITCH: begin
        cmd.sw_commit = 1'b1;
      end
      S_ROUTE: begin
        if (sts.func == FUNC_BACKUP) begin
          cmd.wgt_go  = sts.prev_valid;
          cmd.wgt_sel = WGT_BACKUP;
          cmd.lim_go  = !sts.prev_valid;
          cmd.lim_sel = LIM_APPROVE;
        end
      end
      S_WGT_B: begin
        cmd.wgt_go  = !sts.wgt_busy;
        cmd.wgt_sel = WGT_PRIMARY;
      end
      S_WGT_P: begin
        cmd.lim_go  = !sts.wgt_busy;
        cmd.lim_sel = LIM_APPROVE;
      end
      S_LIM_AP: begin
      end
      S_UPDATE: begin
        cmd.upd = 1'b1;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/ahb_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the adaptive hedging budget: window state, serial ratio
// multiplier, delay divider, window weighting unit and result register.
// Depends on ahb_pkg.
module ahb_dp #(
  parameter int COUNTER_BITS = ahb_pkg::COUNTER_BITS_DEF,
  parameter int TIME_BITS    = ahb_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ahb_pkg::ahb_cfg_t           cfg,
  input  ahb_pkg::ahb_cmd_t           cmd,
  output ahb_pkg::ahb_sts_t           sts,
  input  logic                        in_func,
  input  logic [ahb_pkg::COUNT_W-1:0] in_count,
  input  logic [TIME_BITS-1:0]        in_now,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ahb_pkg::DELAY_W-1:0] out_delay,
  output logic                        out_approved
);
  import ahb_pkg::*;

  localparam int LIM_W     = COUNTER_BITS + RATIO_W;
  localparam int LCNT_W    = $clog2(RATIO_W + 1);
  localparam int WCNT_W    = $clog2(COUNTER_BITS);
  localparam int TCNT_W    = $clog2(TQ_W);
  localparam int TPROD_W   = DELAY_W + TUNE_W;

  function automatic logic [COUNTER_BITS-1:0] sat_add(
    input logic [COUNTER_BITS-1:0] a,
    input logic [COUNTER_BITS-1:0] b
  );
    logic [COUNTER_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COUNTER_BITS] ? {COUNTER_BITS{1'b1}} : s[COUNTER_BITS-1:0];
  endfunction

  // Captured item
  logic                    func_r;
  logic [COUNT_W-1:0]      count_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [COUNTER_BITS-1:0] cnt_ext;

  // Window state
  logic [TIME_BITS-1:0]    win_start_r, elapsed_r;
  logic [DELAY_W-1:0]      cur_delay_r;
  logic [COUNTER_BITS-1:0] pri_r, att_r, bak_r, ppri_r, pbak_r;
  logic                    prev_valid_r;
  logic [COUNTER_BITS-1:0] wb_r, wp_r;
  logic                    appr_r;

  // Ratio multiply-compare unit
  logic                    lim_busy_r, lim_hit_r;
  logic [LCNT_W-1:0]       lcnt_r;
  logic [COUNTER_BITS-1:0] lp_r, lb_r;
  logic [RATIO_W-1:0]      lr_r;
  logic [LIM_W-1:0]        lacc_r;
  logic [COUNTER_BITS-1:0] lp_sel, lb_sel;

  // Delay tuning unit
  logic                    tune_busy_r;
  logic [TCNT_W-1:0]       tcnt_r;
  logic [TQ_W-1:0]         tq_r;
  logic [TUNE_W-1:0]       trem_r;
  logic [TPROD_W-1:0]      tprod;
  logic [TUNE_W:0]         trsh;
  logic [DELAY_W-1:0]      dmax, dclamp;

  // Weighting unit
  logic                    wgt_busy_r, wsel_r;
  logic [WCNT_W-1:0]       wcnt_r;
  logic [COUNTER_BITS-1:0] wa_r, wq_r, wq_shift, wq_step, wprev;
  logic [TICK_W-1:0]       wr_r, w_r, wr_step;
  logic [TICK_W+1:0]       wx, wt1, wt2;

  // Result register
  logic                    out_tvalid_r;
  logic [DELAY_W-1:0]      out_delay_r;
  logic                    out_appr_r;

  assign cnt_ext = COUNTER_BITS'(count_r);

  // Status to the sequencer
  always_comb begin
    sts.switch_due = elapsed_r > TIME_BITS'(cfg.tick_period);
    sts.func       = func_r;
    sts.prev_valid = prev_valid_r;
    sts.lim_busy   = lim_busy_r;
    sts.tune_busy  = tune_busy_r;
    sts.wgt_busy   = wgt_busy_r;
    sts.out_free   = !out_tvalid_r || out_tready;
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r  <= in_func;
      count_r <= in_count;
      now_r   <= in_now;
    end
  end

  // Clamp the tuned delay; min_delay wins over max_delay
  always_comb begin
    dmax   = (tq_r > TQ_W'(cfg.max_delay)) ? cfg.max_delay : tq_r[DELAY_W-1:0];
    dclamp = (dmax < cfg.min_delay) ? cfg.min_delay : dmax;
  end

  // Window state: switch, counter update, weighted sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r  <= '0;
      elapsed_r    <= '0;
      cur_delay_r  <= MAX_DELAY_RST;
      pri_r        <= '0;
      att_r        <= '0;
      bak_r        <= '0;
      ppri_r       <= '0;
      pbak_r       <= '0;
      prev_valid_r <= 1'b0;
      wb_r         <= '0;
      wp_r         <= '0;
      appr_r       <= 1'b0;
    end else begin
      if (cmd.cap) begin
        elapsed_r <= in_now - win_start_r;
        wb_r      <= '0;
        wp_r      <= '0;
        appr_r    <= 1'b0;
      end
      // close the window
      if (cmd.sw_commit) begin
        cur_delay_r  <= dclamp;
        ppri_r       <= pri_r;
        pbak_r       <= bak_r;
        prev_valid_r <= 1'b1;
        pri_r        <= '0;
        att_r        <= '0;
        bak_r        <= '0;
        win_start_r  <= now_r;
        elapsed_r    <= '0;
      end
      // count the item
      if (cmd.upd) begin
        if (func_r == FUNC_PRIMARY) begin
          pri_r <= sat_add(pri_r, cnt_ext);
        end else begin
          att_r  <= sat_add(att_r, cnt_ext);
          appr_r <= !lim_hit_r;
          if (!lim_hit_r) bak_r <= sat_add(bak_r, cnt_ext);
        end
      end
      // store weighted previous counts
      if (cmd.wgt_go && cfg.tick_period == '0) begin
        if (cmd.wgt_sel == WGT_BACKUP) wb_r <= wprev;
        else wp_r <= wprev;
      end else if (wgt_busy_r && wcnt_r == '0) begin
        if (wsel_r == WGT_BACKUP) wb_r <= wq_step;
        else wp_r <= wq_step;
      end
    end
  end

  // Operands of the ratio unit
  always_comb begin
    if (cmd.lim_sel == LIM_SWITCH) begin
      lp_sel = pri_r;
      lb_sel = att_r;
    end else begin
      lp_sel = sat_add(pri_r, wp_r);
      lb_sel = sat_add(bak_r, wb_r);
    end
  end

  // Ratio unit: primaries*ratio one ratio bit a cycle, then compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_busy_r <= 1'b0;
      lim_hit_r  <= 1'b0;
      lcnt_r     <= '0;
    end else if (cmd.lim_go) begin
      lim_busy_r <= 1'b1;
      lcnt_r     <= LCNT_W'(RATIO_W);
      lp_r       <= lp_sel;
      lb_r       <= lb_sel;
      lr_r       <= cfg.backup_ratio;
      lacc_r     <= '0;
    end else if (lim_busy_r) begin
      if (lcnt_r != '0) begin
        lacc_r <= {lacc_r[LIM_W-2:0], 1'b0} +
                  (lr_r[RATIO_W-1] ? LIM_W'(lp_r) : {LIM_W{1'b0}});
        lr_r   <= {lr_r[RATIO_W-2:0], 1'b0};
        lcnt_r <= lcnt_r - 1'b1;
      end else begin
        lim_hit_r  <= LIM_W'({lb_r, {RATIO_FRAC{1'b0}}}) >= lacc_r;
        lim_busy_r <= 1'b0;
      end
    end
  end

  // Tuning: product computed combinationally, or restoring division one bit a cycle
  assign tprod = TPROD_W'(cur_delay_r) * TPROD_W'(cfg.tune_factor);
  assign trsh  = {trem_r, tq_r[TQ_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tune_busy_r <= 1'b0;
      tcnt_r      <= '0;
    end else if (cmd.tune_go) begin
      trem_r <= '0;
      tcnt_r <= TCNT_W'(TQ_W - 1);
      if (lim_hit_r) begin
        tq_r <= tprod[TPROD_W-1:TUNE_FRAC];
      end else if (cfg.tune_factor == '0) begin
        tq_r <= '1;
      end else begin
        tq_r        <= {cur_delay_r, {TUNE_FRAC{1'b0}}};
        tune_busy_r <= 1'b1;
      end
    end else if (tune_busy_r) begin
      if (trsh >= {1'b0, cfg.tune_factor}) begin
        trem_r <= TUNE_W'(trsh - {1'b0, cfg.tune_factor});
        tq_r   <= {tq_r[TQ_W-2:0], 1'b1};
      end else begin
        trem_r <= trsh[TUNE_W-1:0];
        tq_r   <= {tq_r[TQ_W-2:0], 1'b0};
      end
      tcnt_r <= tcnt_r - 1'b1;
      if (tcnt_r == '0) tune_busy_r <= 1'b0;
    end
  end

  // Weighting step: fold one bit of prev into quotient and remainder mod tick
  assign wprev = (cmd.wgt_sel == WGT_BACKUP) ? pbak_r : ppri_r;

  always_comb begin
    wx       = {1'b0, wr_r, 1'b0} + (wa_r[COUNTER_BITS-1] ? {2'b00, w_r} : '0);
    wt1      = {2'b00, cfg.tick_period};
    wt2      = {1'b0, cfg.tick_period, 1'b0};
    wq_shift = {wq_r[COUNTER_BITS-2:0], 1'b0};
    if (wx >= wt2) begin
      wr_step = TICK_W'(wx - wt2);
      wq_step = wq_shift + COUNTER_BITS'(2);
    end else if (wx >= wt1) begin
      wr_step = TICK_W'(wx - wt1);
      wq_step = wq_shift + COUNTER_BITS'(1);
    end else begin
      wr_step = wx[TICK_W-1:0];
      wq_step = wq_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_busy_r <= 1'b0;
      wcnt_r     <= '0;
    end else if (cmd.wgt_go) begin
      wsel_r     <= cmd.wgt_sel;
      wa_r       <= wprev;
      w_r        <= cfg.tick_period - elapsed_r[TICK_W-1:0];
      wr_r       <= '0;
      wq_r       <= '0;
      wcnt_r     <= WCNT_W'(COUNTER_BITS - 1);
      wgt_busy_r <= cfg.tick_period != '0;
    end else if (wgt_busy_r) begin
      wa_r   <= {wa_r[COUNTER_BITS-2:0], 1'b0};
      wr_r   <= wr_step;
      wq_r   <= wq_step;
      wcnt_r <= wcnt_r - 1'b1;
      if (wcnt_r == '0) wgt_busy_r <= 1'b0;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_delay_r <= cur_delay_r;
      out_appr_r  <= appr_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_delay    = out_delay_r;
  assign out_approved = out_appr_r;

  // Checks
  ap_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten before it was taken");

  ap_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    lim_busy_r |-> !(wgt_busy_r || tune_busy_r))
    else $error("serial units running at the same time");

  ap_switch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sw_commit |=> (elapsed_r == '0 && prev_valid_r && pri_r == '0 && att_r == '0))
    else $error("window switch left stale counters");

  ap_delay_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sw_commit |=> (cur_delay_r >= $past(cfg.min_delay) &&
      (cur_delay_r <= $past(cfg.max_delay) || cur_delay_r == $past(cfg.min_delay))))
    else $error("tuned delay outside its clamp");

endmodule

@@ rtl/adaptive_hedging_budget_core.sv @@
`timescale 1ns / 1ps
// Adaptive hedging budget, top level: stream ports, configuration registers,
// sequencer and datapath. Depends on ahb_pkg, ahb_ctrl and ahb_dp.
//
// One item is worked on at a time and yields exactly one result. A primary
// item that closes no window is checked, counted and loaded into the output
// register. Closing a window adds the ratio multiply-compare (one ratio bit
// a cycle, then the compare), the delay tuning (a product when the ratio was
// hit, else a restoring division of the delay by tune_factor, all ones when
// tune_factor is zero) and the commit of the new window. A backup item adds
// the ratio unit once more and, once a previous window exists, two passes of
// the weighting unit (the previous counts are stored directly when
// tick_period is zero). The next item is accepted as soon as the previous
// result has reached the output register; a result that is not taken stalls
// the next item before its result is loaded, until it is taken.
module adaptive_hedging_budget_core #(
  parameter int COUNTER_BITS = ahb_pkg::COUNTER_BITS_DEF,
  parameter int TIME_BITS    = ahb_pkg::TIME_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  // in_tdata: count [15:0], now [TIME_BITS+15:16], zero padding above
  input  logic [((TIME_BITS + ahb_pkg::COUNT_W + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: func
  input  logic                                                     in_tuser,
  input  logic                                                     in_tvalid,
  output logic                                                     in_tready,
  // out_tdata: delay [31:0], approved [32], zero padding above
  output logic [ahb_pkg::OUT_DATA_W-1:0]                           out_tdata,
  output logic                                                     out_tvalid,
  input  logic                                                     out_tready,
  input  logic                                                     cfg_valid,
  output logic                                                     cfg_ready,
  input  logic [ahb_pkg::CFG_IDX_W-1:0]                            cfg_index,
  input  logic [ahb_pkg::CFG_DATA_W-1:0]                           cfg_data
);
  import ahb_pkg::*;

  ahb_cfg_t           cfg_r;
  ahb_cmd_t           cmd;
  ahb_sts_t           sts;
  logic [DELAY_W-1:0] out_delay;
  logic               out_approved;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period  <= TICK_PERIOD_RST;
      cfg_r.min_delay    <= MIN_DELAY_RST;
      cfg_r.max_delay    <= MAX_DELAY_RST;
      cfg_r.tune_factor  <= TUNE_FACTOR_RST;
      cfg_r.backup_ratio <= BACKUP_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICK_PERIOD:  cfg_r.tick_period  <= cfg_data[TICK_W-1:0];
        REG_MIN_DELAY:    cfg_r.min_delay    <= cfg_data[DELAY_W-1:0];
        REG_MAX_DELAY:    cfg_r.max_delay    <= cfg_data[DELAY_W-1:0];
        REG_TUNE_FACTOR:  cfg_r.tune_factor  <= cfg_data[TUNE_W-1:0];
        REG_BACKUP_RATIO: cfg_r.backup_ratio <= cfg_data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ahb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ahb_dp #(
    .COUNTER_BITS (COUNTER_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_tuser),
    .in_count     (in_tdata[COUNT_W-1:0]),
    .in_now       (in_tdata[COUNT_W +: TIME_BITS]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_delay    (out_delay),
    .out_approved (out_approved)
  );

  // Pack the result item
  assign out_tdata = {{(OUT_DATA_W - DELAY_W - 1){1'b0}}, out_approved, out_delay};

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of adaptive_hedging_budget_core: directed and random items
// with random idling on both streams, checked against an in-bench budget predictor.
// Depends on ahb_pkg and the RTL of the block.
module testbench;
  import ahb_pkg::*;

  localparam int TIME_BITS = TIME_BITS_DEF;
  localparam int IN_W      = ((TIME_BITS + COUNT_W + 7) / 8) * 8;
  localparam logic [63:0] CNT_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               granted;
  } hedge_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Budget state and register copy of the predictor
  ahb_cfg_t           regs = '{TICK_PERIOD_RST, MIN_DELAY_RST, MAX_DELAY_RST,
                               TUNE_FACTOR_RST, BACKUP_RATIO_RST};
  logic [TIME_BITS-1:0] win_start = '0;
  logic [DELAY_W-1:0] cur_delay = MAX_DELAY_RST;
  logic [63:0]        prim_cnt = '0;
  logic [63:0]        att_cnt = '0;
  logic [63:0]        bak_cnt = '0;
  logic [63:0]        prev_prim = '0;
  logic [63:0]        prev_bak = '0;
  bit                 prev_seen = 1'b0;

  hedge_reply_t       due_replies[$];
  int                 fail_count = 0;
  bit                 gaps_on = 1'b0;
  bit                 stall_on = 1'b0;
  bit                 in_held = 1'b0;
  int                 stall_left = 0;
  logic [TIME_BITS-1:0] stamp = '0;

  adaptive_hedging_budget_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Counter sum, held at the counter ceiling
  function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return (s > CNT_MAX) ? CNT_MAX : s[63:0];
  endfunction

  // Backups have used up the share that the ratio allows on these primaries
  function automatic bit budget_spent(input logic [63:0] p, input logic [63:0] b);
    logic [95:0] lhs;
    logic [95:0] rhs;
    lhs = {32'b0, b} << RATIO_FRAC;
    rhs = {32'b0, p} * {76'b0, regs.backup_ratio};
    return lhs >= rhs;
  endfunction

  // Previous-window count scaled by the part of the window still to run
  function automatic logic [63:0] faded_share(input logic [63:0] prev,
                                              input logic [TIME_BITS-1:0] el);
    logic [127:0] prod;
    logic [63:0]  rest;
    if (regs.tick_period == 0) return prev;
    rest = {32'b0, regs.tick_period} - {16'b0, el};
    prod = {64'b0, prev} * {64'b0, rest};
    return 64'(prod / {96'b0, regs.tick_period});
  endfunction

  // Advance the budget by one item and return the reply it should give
  function automatic hedge_reply_t predict_budget(input logic f, input logic [COUNT_W-1:0] c,
                                                  input logic [TIME_BITS-1:0] t);
    logic [TIME_BITS-1:0] el;
    logic [63:0]          d;
    logic [63:0]          p;
    logic [63:0]          b;
    hedge_reply_t         r;
    el = t - win_start;
    r.granted = 1'b0;
    // Close the window: retune and clamp the delay, roll the counters
    if ({16'b0, el} > {32'b0, regs.tick_period}) begin
      d = {32'b0, cur_delay};
      if (budget_spent(prim_cnt, att_cnt))
        d = (d * {48'b0, regs.tune_factor}) >> TUNE_FRAC;
      else if (regs.tune_factor != 0)
        d = (d << TUNE_FRAC) / {48'b0, regs.tune_factor};
      else
        d = '1;
      if (d > {32'b0, regs.max_delay}) d = {32'b0, regs.max_delay};
      if (d < {32'b0, regs.min_delay}) d = {32'b0, regs.min_delay};
      cur_delay = d[DELAY_W-1:0];
      prev_prim = prim_cnt;
      prev_bak  = bak_cnt;
      prev_seen = 1'b1;
      prim_cnt  = '0;
      att_cnt   = '0;
      bak_cnt   = '0;
      win_start = t;
      el = '0;
    end
    if (f == FUNC_PRIMARY) begin
      prim_cnt = capped_sum(prim_cnt, {48'b0, c});
    end else begin
      b = bak_cnt;
      p = prim_cnt;
      if (prev_seen) begin
        b = capped_sum(b, faded_share(prev_bak, el));
        p = capped_sum(p, faded_share(prev_prim, el));
      end
      att_cnt = capped_sum(att_cnt, {48'b0, c});
      r.granted = !budget_spent(p, b);
      if (r.granted) bak_cnt = capped_sum(bak_cnt, {48'b0, c});
    end
    r.delay = cur_delay;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Receiver side: random back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left <= pick_gap(1'b1);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest reply due
  always @(posedge clk) begin
    hedge_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_replies.size() == 0) begin
        report_mismatch("result with none due", 64'(out_tdata), 64'd0);
      end else begin
        want = due_replies.pop_front();
        if (out_tdata[DELAY_W-1:0] !== want.delay)
          report_mismatch("delay", 64'(out_tdata[DELAY_W-1:0]), 64'(want.delay));
        if (out_tdata[DELAY_W] !== want.granted)
          report_mismatch("approved", 64'(out_tdata[DELAY_W]), 64'(want.granted));
      end
    end
  end

  // Offer one item, wait for its handshake, record the reply due
  task automatic send_item(input logic f, input logic [COUNT_W-1:0] c,
                           input logic [TIME_BITS-1:0] t);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      if (in_held) begin
        in_tvalid <= 1'b0;
        in_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {t, c};
    in_held = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due_replies.push_back(predict_budget(f, c, t));
  endtask

  // Drop the input and hold until every reply due has come
  task automatic settle_replies();
    if (in_held) begin
      in_tvalid <= 1'b0;
      in_held = 1'b0;
    end
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  // Write all five registers while the block is idle
  task automatic load_regs(input logic [31:0] tick, input logic [31:0] mn,
                           input logic [31:0] mx, input logic [TUNE_W-1:0] tune,
                           input logic [RATIO_W-1:0] ratio);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idx [5];
    settle_replies();
    vals = '{tick, mn, mx, 32'(tune), 32'(ratio)};
    idx  = '{REG_TICK_PERIOD, REG_MIN_DELAY, REG_MAX_DELAY, REG_TUNE_FACTOR,
             REG_BACKUP_RATIO};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        REG_TICK_PERIOD:  regs.tick_period  = vals[k];
        REG_MIN_DELAY:    regs.min_delay    = vals[k];
        REG_MAX_DELAY:    regs.max_delay    = vals[k];
        REG_TUNE_FACTOR:  regs.tune_factor  = vals[k][TUNE_W-1:0];
        REG_BACKUP_RATIO: regs.backup_ratio = vals[k][RATIO_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: fill a window, hit the ratio, close it on the grow path (clamped at max_delay)
  task automatic test_default_window();
    send_item(FUNC_PRIMARY, 16'd100, 48'd10);
    send_item(FUNC_BACKUP, 16'd5, 48'd20);
    send_item(FUNC_BACKUP, 16'hFFFF, 48'd30);
    send_item(FUNC_BACKUP, 16'd1, 48'd40);
    send_item(FUNC_PRIMARY, 16'hFFFF, 48'd1_000_100);
    send_item(FUNC_BACKUP, 16'd0, 48'd1_500_000);
  endtask

  // Time stamp at both ends, wrap-around and time going backwards
  task automatic test_time_wrap();
    send_item(FUNC_PRIMARY, 16'd1, 48'hFFFF_FFFF_FFFF);
    send_item(FUNC_BACKUP, 16'd2, 48'd0);
    send_item(FUNC_PRIMARY, 16'd3, 48'h8000_0000_0000);
    send_item(FUNC_BACKUP, 16'd4, 48'd100);
  endtask

  // Register extremes: zero tick, zero tune, min above max, zero and full ratio
  task automatic test_reg_extremes();
    load_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 20'hFFFFF);
    send_item(FUNC_PRIMARY, 16'd9, 48'd1000);
    send_item(FUNC_BACKUP, 16'd1, 48'd1000);
    send_item(FUNC_PRIMARY, 16'd0, 48'd1001);
    send_item(FUNC_BACKUP, 16'd3, 48'd1001);
    send_item(FUNC_PRIMARY, 16'd0, 48'd1002);
    load_regs(32'd1, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 20'd0);
    send_item(FUNC_PRIMARY, 16'hFFFF, 48'd2000);
    send_item(FUNC_PRIMARY, 16'd1, 48'd2002);
    send_item(FUNC_BACKUP, 16'hFFFF, 48'd2003);
    load_regs(32'hFFFF_FFFF, 32'd0, 32'd100000, 16'd256, 20'hFFFFF);
    send_item(FUNC_PRIMARY, 16'd500, 48'd2004);
    send_item(FUNC_BACKUP, 16'd700, 48'd2005);
    send_item(FUNC_BACKUP, 16'hFFFF, 48'h0001_0000_07D5);
    send_item(FUNC_BACKUP, 16'd10, 48'h0001_0000_07DA);
    stamp = 48'h0001_0000_07DA;
  endtask

  // Random but mostly sensible register set
  task automatic random_regs();
    logic [31:0]        tick;
    logic [31:0]        mn;
    logic [31:0]        mx;
    logic [TUNE_W-1:0]  tune;
    logic [RATIO_W-1:0] ratio;
    case ($urandom_range(0, 3))
      0:       tick = $urandom_range(1, 16);
      1:       tick = $urandom_range(100, 100000);
      2:       tick = $urandom;
      default: tick = 32'hFFFF_FFFF;
    endcase
    mx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 10_000_000);
    case ($urandom_range(0, 7))
      0, 1, 2: mn = '0;
      3:       mn = $urandom;
      default: mn = $urandom_range(0, mx);
    endcase
    tune  = ($urandom_range(0, 1) == 0) ? TUNE_W'($urandom_range(256, 1024))
                                        : TUNE_W'($urandom_range(256, 65535));
    ratio = ($urandom_range(0, 2) == 0) ? RATIO_W'($urandom_range(0, 1048575))
                                        : RATIO_W'($urandom_range(0, 65536));
    load_regs(tick, mn, mx, tune, ratio);
  endtask

  // Random windows of primaries and backups; optionally drain every few items
  task automatic random_burst(input int n, input int pause_every);
    logic [63:0]        span;
    logic [63:0]        wide;
    logic [COUNT_W-1:0] c;
    logic               f;
    int                 r;
    for (int k = 0; k < n; k++) begin
      if (pause_every > 0 && k % pause_every == 0) settle_replies();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        wide  = {$urandom, $urandom};
        stamp = wide[TIME_BITS-1:0];
      end else begin
        if (r < 13)
          span = '0;
        else if (r < 85)
          span = $urandom_range(0, regs.tick_period / 4);
        else
          span = 64'(regs.tick_period) + $urandom_range(1, regs.tick_period / 2 + 1);
        stamp = stamp + span[TIME_BITS-1:0];
      end
      f = 1'($urandom_range(0, 1));
      c = COUNT_W'($urandom & ((32'h1 << $urandom_range(1, COUNT_W)) - 1));
      send_item(f, c, stamp);
    end
  endtask

  // Random phases with fresh registers, varying idling and one drained phase
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on  = (ph != 0 && ph != 2);
      stall_on = (ph != 0 && ph != 1);
      random_regs();
      random_burst(250, (ph == 4) ? 40 : 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_window();
    test_time_wrap();
    test_reg_extremes();
    test_random_phases();
    settle_replies();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
